### rtl/rtwb_pkg.sv
// rtwb_pkg: shared types and constants for the request tracker with breaker.
// Used by the top level and the testbench; depends on nothing.
package rtwb_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TALLY_W   = 8;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned ENTRY_W   = ID_W + TIME_W;

  localparam logic [TALLY_W-1:0] THRESH_RST     = 8'd5;
  localparam logic [TIME_W-1:0]  OPEN_TICKS_RST = 32'd60000;
  localparam logic [TIME_W-1:0]  TIMEOUT_RST    = 32'd30000;
  localparam logic [ID_W-1:0]    FIRST_ID       = 16'd1;
  localparam logic [ID_W-1:0]    LAST_ID        = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_SEND = 2'd0,
    OP_RESP = 2'd1,
    OP_TICK = 2'd2,
    OP_FAIL = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    K_ACCEPT  = 3'd0,
    K_BREAKER = 3'd1,
    K_FULL    = 3'd2,
    K_MATCH   = 3'd3,
    K_UNKNOWN = 3'd4,
    K_TIMEOUT = 3'd5,
    K_TICK    = 3'd6,
    K_FAILURE = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAIL_THRESH = 2'd0,
    REG_OPEN_TICKS  = 2'd1,
    REG_TIMEOUT     = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND_BRK,
    ST_SEND_SCAN,
    ST_RESP_SCAN,
    ST_RESP_UPD,
    ST_TICK_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] response_id;
    logic            response_is_error;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_t;

endpackage

### rtl/rtwb_chan_if.sv
// rtwb_chan_if: valid/ready channel carrying one payload type per instance.
// Payload types come from rtwb_pkg at the place of instantiation.
interface rtwb_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/rtwb_ram.sv
// rtwb_ram: generic single-write, single-read RAM with registered read data.
// Standalone; read returns the old contents on a same-address write.
module rtwb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/request_tracker_with_breaker.sv
// request_tracker_with_breaker: outstanding request table gated by a circuit breaker.
// Depends on rtwb_pkg, rtwb_chan_if and rtwb_ram (id and send time per slot).
//
// channel  dir  payload                                      accepted when
// req_i    in   operation, response_id, response_is_error    valid && ready
// rsp_o    out  kind                                         valid && ready
// cfg_i    in   index, data (register write)                 valid && ready
//
// one transaction at a time: req_i is ready only while the sequencer is idle.
// send: breaker check, free-slot scan; response: id scan, update; failure: no scan;
// tick: scan of all slots. Each waits on rsp_o to free the result register. The table
// is walked one slot per cycle (a tick stalls on an expired slot) through the RAM read
// port and one shared subtract-and-compare unit; the result register frees req_i from
// rsp_o. reset clears breaker, counters and slot valid bits at once, no clearing pass.
module request_tracker_with_breaker
  import rtwb_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtwb_chan_if.sink   req_i,
  rtwb_chan_if.source rsp_o,
  rtwb_chan_if.sink   cfg_i
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  kind_e kind_q, kind_d;
  logic [ID_W-1:0] resp_id_q, resp_id_d;
  logic resp_err_q, resp_err_d;
  logic [TIME_W-1:0] lat_q, lat_d;

  logic [TALLY_W-1:0] thresh_q;
  logic [TIME_W-1:0]  open_ticks_q, timeout_q;

  mode_e mode_q, mode_d;
  logic [TALLY_W-1:0] tally_q, tally_d;
  logic [TIME_W-1:0]  last_fail_q, last_fail_d;
  logic [TIME_W-1:0]  time_now_q, time_now_d;
  logic [ID_W-1:0]    next_id_q, next_id_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [TIME_W-1:0]  lat_min_q, lat_min_d, lat_max_q, lat_max_d;
  logic [SUM_W-1:0]   lat_sum_q, lat_sum_d;
  logic [CNT_W-1:0]   ok_cnt_q, ok_cnt_d, fail_cnt_q, fail_cnt_d, sent_cnt_q, sent_cnt_d;

  logic out_valid_q, out_valid_d;
  kind_e out_kind_q, out_kind_d;
  logic out_free, emit;
  kind_e emit_kind;

  logic brk_fail, brk_ok;
  logic [TALLY_W-1:0] tally_inc;

  logic ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ID_W-1:0] slot_id;
  logic [TIME_W-1:0] slot_time;

  // shared elapsed-time unit
  logic [TIME_W-1:0] sub_b, sub_lim, elapsed;
  logic elapsed_gt;

  logic [SUM_W:0] sum_ext;

  assign slot_id   = ram_rdata[ENTRY_W-1:TIME_W];
  assign slot_time = ram_rdata[TIME_W-1:0];

  always_comb begin
    if (state_q == ST_SEND_BRK) begin
      sub_b   = last_fail_q;
      sub_lim = open_ticks_q;
    end else begin
      sub_b   = slot_time;
      sub_lim = timeout_q;
    end
    elapsed    = time_now_q - sub_b;
    elapsed_gt = elapsed > sub_lim;
  end

  // read address follows idx_d so ram_rdata always belongs to slot idx_q
  rtwb_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i({next_id_q, time_now_q}),
    .raddr_i(idx_d),
    .rdata_o(ram_rdata)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data.kind = out_kind_q;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign sum_ext = {1'b0, lat_sum_q} + (SUM_W + 1)'(lat_q);
  assign tally_inc = (tally_q == '1) ? tally_q : tally_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    kind_d      = kind_q;
    resp_id_d   = resp_id_q;
    resp_err_d  = resp_err_q;
    lat_d       = lat_q;
    mode_d      = mode_q;
    tally_d     = tally_q;
    last_fail_d = last_fail_q;
    time_now_d  = time_now_q;
    next_id_d   = next_id_q;
    valid_d     = valid_q;
    lat_min_d   = lat_min_q;
    lat_max_d   = lat_max_q;
    lat_sum_d   = lat_sum_q;
    ok_cnt_d    = ok_cnt_q;
    fail_cnt_d  = fail_cnt_q;
    sent_cnt_d  = sent_cnt_q;
    emit        = 1'b0;
    emit_kind   = kind_q;
    brk_fail    = 1'b0;
    brk_ok      = 1'b0;
    ram_we      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (req_i.valid) begin
          resp_id_d  = req_i.data.response_id;
          resp_err_d = req_i.data.response_is_error;
          unique case (op_e'(req_i.data.operation))
            OP_SEND: state_d = ST_SEND_BRK;
            OP_RESP: state_d = ST_RESP_SCAN;
            OP_TICK: begin
              time_now_d = time_now_q + 1'b1;
              state_d    = ST_TICK_SCAN;
            end
            OP_FAIL: begin
              brk_fail = 1'b1;
              kind_d   = K_FAILURE;
              state_d  = ST_DONE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SEND_BRK: begin
        if (mode_q == MODE_OPEN && !elapsed_gt) begin
          kind_d  = K_BREAKER;
          state_d = ST_DONE;
        end else begin
          if (mode_q == MODE_OPEN) begin
            mode_d = MODE_HALF;
          end
          state_d = ST_SEND_SCAN;
        end
      end
      ST_SEND_SCAN: begin
        if (!valid_q[idx_q]) begin
          valid_d[idx_q] = 1'b1;
          ram_we         = 1'b1;
          next_id_d      = (next_id_q == LAST_ID) ? FIRST_ID : next_id_q + 1'b1;
          sent_cnt_d     = (sent_cnt_q == '1) ? sent_cnt_q : sent_cnt_q + 1'b1;
          kind_d         = K_ACCEPT;
          state_d        = ST_DONE;
        end else if (idx_q == LAST_IDX) begin
          kind_d  = K_FULL;
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RESP_SCAN: begin
        if (valid_q[idx_q] && slot_id == resp_id_q) begin
          valid_d[idx_q] = 1'b0;
          lat_d          = elapsed;
          state_d        = ST_RESP_UPD;
        end else if (idx_q == LAST_IDX) begin
          kind_d  = K_UNKNOWN;
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RESP_UPD: begin
        lat_sum_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        if (lat_q > lat_max_q) begin
          lat_max_d = lat_q;
        end
        if (lat_q < lat_min_q) begin
          lat_min_d = lat_q;
        end
        if (resp_err_q) begin
          fail_cnt_d = (fail_cnt_q == '1) ? fail_cnt_q : fail_cnt_q + 1'b1;
          brk_fail   = 1'b1;
        end else begin
          ok_cnt_d = (ok_cnt_q == '1) ? ok_cnt_q : ok_cnt_q + 1'b1;
          brk_ok   = 1'b1;
        end
        kind_d  = K_MATCH;
        state_d = ST_DONE;
      end
      ST_TICK_SCAN: begin
        if (valid_q[idx_q] && elapsed_gt) begin
          // expired slot: hold here until the result register frees up
          if (out_free) begin
            valid_d[idx_q] = 1'b0;
            fail_cnt_d     = (fail_cnt_q == '1) ? fail_cnt_q : fail_cnt_q + 1'b1;
            brk_fail       = 1'b1;
            emit           = 1'b1;
            emit_kind      = K_TIMEOUT;
            if (idx_q == LAST_IDX) begin
              kind_d  = K_TICK;
              state_d = ST_DONE;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
        end else if (idx_q == LAST_IDX) begin
          kind_d  = K_TICK;
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = kind_q;
          idx_d     = '0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (brk_fail) begin
      tally_d     = tally_inc;
      last_fail_d = time_now_q;
      if (tally_inc >= thresh_q || mode_q == MODE_HALF) begin
        mode_d = MODE_OPEN;
      end
    end else if (brk_ok && mode_q == MODE_HALF) begin
      mode_d  = MODE_CLOSED;
      tally_d = '0;
    end
  end

  always_comb begin
    out_kind_d = out_kind_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = emit_kind;
    end else begin
      out_valid_d = out_valid_q && !rsp_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      thresh_q     <= THRESH_RST;
      open_ticks_q <= OPEN_TICKS_RST;
      timeout_q    <= TIMEOUT_RST;
      mode_q       <= MODE_CLOSED;
      tally_q      <= '0;
      last_fail_q  <= '0;
      time_now_q   <= '0;
      next_id_q    <= FIRST_ID;
      valid_q      <= '0;
      lat_min_q    <= '1;
      lat_max_q    <= '0;
      lat_sum_q    <= '0;
      ok_cnt_q     <= '0;
      fail_cnt_q   <= '0;
      sent_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      mode_q      <= mode_d;
      tally_q     <= tally_d;
      last_fail_q <= last_fail_d;
      time_now_q  <= time_now_d;
      next_id_q   <= next_id_d;
      valid_q     <= valid_d;
      lat_min_q   <= lat_min_d;
      lat_max_q   <= lat_max_d;
      lat_sum_q   <= lat_sum_d;
      ok_cnt_q    <= ok_cnt_d;
      fail_cnt_q  <= fail_cnt_d;
      sent_cnt_q  <= sent_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          REG_FAIL_THRESH: thresh_q     <= cfg_i.data.data[TALLY_W-1:0];
          REG_OPEN_TICKS:  open_ticks_q <= cfg_i.data.data[TIME_W-1:0];
          REG_TIMEOUT:     timeout_q    <= cfg_i.data.data[TIME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    resp_id_q  <= resp_id_d;
    resp_err_q <= resp_err_d;
    lat_q      <= lat_d;
    out_kind_q <= out_kind_d;
  end

endmodule

### tb/rtwb_result_checker.sv
`timescale 1ns / 1ps
// rtwb_result_checker: watches the request, result and register channels of the
// request tracker, predicts the result kinds of every transaction and compares them in order.
// Depends on rtwb_pkg; instantiated beside the block by request_tracker_with_breaker_tb.
module rtwb_result_checker
  import rtwb_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic            req_ready_i,
  input  req_t            req_data_i,
  input  logic            rsp_valid_i,
  input  logic            rsp_ready_i,
  input  rsp_t            rsp_data_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  cfg_t            cfg_data_i,
  output int unsigned     mismatch_count_o,
  output int unsigned     pending_o,
  output logic [ID_W-1:0] next_id_o
);

  localparam int unsigned PRINT_MAX = 20;

  // register copies
  logic [TALLY_W-1:0] thresh;
  logic [TIME_W-1:0]  open_ticks;
  logic [TIME_W-1:0]  timeout_ticks;

  // breaker and table copies
  mode_e              mode;
  logic [TALLY_W-1:0] fail_tally;
  logic [TIME_W-1:0]  last_fail_time;
  logic [TIME_W-1:0]  time_now;
  logic [ID_W-1:0]    next_id;
  logic               slot_valid [TABLE_DEPTH];
  logic [ID_W-1:0]    slot_id    [TABLE_DEPTH];
  logic [TIME_W-1:0]  slot_sent  [TABLE_DEPTH];

  kind_e kinds_due [$];

  assign next_id_o = next_id;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count_o < PRINT_MAX) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatch_count_o++;
  endtask

  task automatic expect_kind(input kind_e k);
    kinds_due = {kinds_due, k};
  endtask

  task automatic breaker_fail();
    if (fail_tally != '1) begin
      fail_tally++;
    end
    last_fail_time = time_now;
    if (fail_tally >= thresh || mode == MODE_HALF) begin
      mode = MODE_OPEN;
    end
  endtask

  task automatic track_item(input req_t item);
    int slot;
    slot = -1;
    case (op_e'(item.operation))
      OP_SEND: begin
        if (mode == MODE_OPEN && (time_now - last_fail_time) <= open_ticks) begin
          expect_kind(K_BREAKER);
        end else begin
          // an open breaker past its hold time lets this send through half-open
          if (mode == MODE_OPEN) begin
            mode = MODE_HALF;
          end
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!slot_valid[i] && slot < 0) begin
              slot = i;
            end
          end
          if (slot < 0) begin
            expect_kind(K_FULL);
          end else begin
            slot_valid[slot] = 1'b1;
            slot_id[slot]    = next_id;
            slot_sent[slot]  = time_now;
            next_id = (next_id == LAST_ID) ? FIRST_ID : next_id + 1'b1;
            expect_kind(K_ACCEPT);
          end
        end
      end
      OP_RESP: begin
        // lowest slot wins when an id is held twice
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (slot < 0 && slot_valid[i] && slot_id[i] == item.response_id) begin
            slot = i;
          end
        end
        if (slot < 0) begin
          expect_kind(K_UNKNOWN);
        end else begin
          slot_valid[slot] = 1'b0;
          if (item.response_is_error) begin
            breaker_fail();
          end else if (mode == MODE_HALF) begin
            mode       = MODE_CLOSED;
            fail_tally = '0;
          end
          expect_kind(K_MATCH);
        end
      end
      OP_TICK: begin
        time_now++;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (slot_valid[i] && (time_now - slot_sent[i]) > timeout_ticks) begin
            slot_valid[i] = 1'b0;
            breaker_fail();
            expect_kind(K_TIMEOUT);
          end
        end
        expect_kind(K_TICK);
      end
      default: begin
        breaker_fail();
        expect_kind(K_FAILURE);
      end
    endcase
  endtask

  task automatic write_reg(input cfg_t wr);
    case (wr.index)
      REG_FAIL_THRESH: thresh        = wr.data[TALLY_W-1:0];
      REG_OPEN_TICKS:  open_ticks    = wr.data[TIME_W-1:0];
      REG_TIMEOUT:     timeout_ticks = wr.data[TIME_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_result(input kind_e got);
    kind_e want;
    if (kinds_due.size() == 0) begin
      flag_mismatch($sformatf("result %s with nothing outstanding", got.name()));
    end else begin
      want = kinds_due.pop_front();
      if (got !== want) begin
        flag_mismatch($sformatf("kind %s, expected %s", got.name(), want.name()));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh         = THRESH_RST;
      open_ticks     = OPEN_TICKS_RST;
      timeout_ticks  = TIMEOUT_RST;
      mode           = MODE_CLOSED;
      fail_tally     = '0;
      last_fail_time = '0;
      time_now       = '0;
      next_id        = FIRST_ID;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_valid[i] = 1'b0;
      end
      kinds_due.delete();
      mismatch_count_o = 0;
    end else begin
      // results first, then register writes, then the new transaction
      if (rsp_valid_i && rsp_ready_i) begin
        check_result(kind_e'(rsp_data_i.kind));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        write_reg(cfg_data_i);
      end
      if (req_valid_i && req_ready_i) begin
        track_item(req_data_i);
      end
    end
    pending_o = kinds_due.size();
  end

endmodule

### tb/request_tracker_with_breaker_tb.sv
`timescale 1ns / 1ps
// request_tracker_with_breaker_tb: drives requests, register writes and result backpressure
// into the request tracker and reports the verdict; rtwb_result_checker does the comparing.
// Depends on rtwb_pkg, rtwb_chan_if, request_tracker_with_breaker and rtwb_result_checker.
module request_tracker_with_breaker_tb;
  import rtwb_pkg::*;

  localparam int unsigned TABLE_DEPTH     = 16;
  localparam int unsigned LIMIT_CYCLES    = 200_000;
  localparam int unsigned SETTLE_CYCLES   = 50;
  localparam int unsigned ITEMS_PER_PHASE = 52;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic            clk_i;
  logic            rst_ni;
  int unsigned     snd_idle_pct;
  int unsigned     rcv_idle_pct;
  int unsigned     hold_left;
  int unsigned     cycles;
  int unsigned     mismatches;
  int unsigned     pending;
  logic [ID_W-1:0] id_hint;

  rtwb_chan_if #(.payload_t(req_t)) req_if ();
  rtwb_chan_if #(.payload_t(rsp_t)) rsp_if ();
  rtwb_chan_if #(.payload_t(cfg_t)) cfg_if ();

  request_tracker_with_breaker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  rtwb_result_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_if.valid),
    .req_ready_i     (req_if.ready),
    .req_data_i      (req_if.data),
    .rsp_valid_i     (rsp_if.valid),
    .rsp_ready_i     (rsp_if.ready),
    .rsp_data_i      (rsp_if.data),
    .cfg_valid_i     (cfg_if.valid),
    .cfg_ready_i     (cfg_if.ready),
    .cfg_data_i      (cfg_if.data),
    .mismatch_count_o(mismatches),
    .pending_o       (pending),
    .next_id_o       (id_hint)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: long hold-off first, otherwise random stalls
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles <= LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // back >= 0 answers the id issued back+1 sends ago, looked up once the edge has settled
  task automatic put_item(input op_e op, input logic [ID_W-1:0] id, input logic err,
                          input int back);
    req_t item;
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item.operation         = op;
    item.response_id       = 16'($urandom);
    item.response_is_error = 1'($urandom);
    if (op == OP_RESP) begin
      item.response_is_error = err;
      item.response_id       = (back >= 0) ? id_hint - 16'd1 - 16'(back) : id;
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned     pick;
    int unsigned     idpick;
    logic [ID_W-1:0] id;
    pick   = $urandom_range(99);
    idpick = $urandom_range(99);
    if (idpick < 10) begin
      id = '0;
    end else if (idpick < 15) begin
      id = LAST_ID;
    end else begin
      id = 16'($urandom);
    end
    if (pick < 35) begin
      put_item(OP_SEND, id, 1'b0, -1);
    end else if (pick < 70) begin
      put_item(OP_RESP, id, ($urandom_range(3) == 0),
               (idpick < 25) ? -1 : int'($urandom_range(6)));
    end else if (pick < 90) begin
      put_item(OP_TICK, id, 1'b0, -1);
    end else begin
      put_item(OP_FAIL, id, 1'b0, -1);
    end
  endtask

  task automatic run_phase(input logic [CFG_DAT_W-1:0] thr, input logic [CFG_DAT_W-1:0] hold,
                           input logic [CFG_DAT_W-1:0] tmo, input int unsigned snd_pct,
                           input int unsigned rcv_pct);
    drain();
    write_reg(REG_FAIL_THRESH, thr);
    write_reg(REG_OPEN_TICKS, hold);
    write_reg(REG_TIMEOUT, tmo);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    repeat (ITEMS_PER_PHASE) random_item();
  endtask

  initial begin
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    snd_idle_pct  = 6;
    rcv_idle_pct  = 82;
    hold_left     = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: match, unknown ids, breaker trips at the threshold
    put_item(OP_SEND, '0, 1'b0, -1);
    put_item(OP_RESP, '0, 1'b0, 0);
    put_item(OP_RESP, '0, 1'b0, -1);
    put_item(OP_RESP, LAST_ID, 1'b1, -1);
    put_item(OP_SEND, '0, 1'b0, -1);
    put_item(OP_RESP, '0, 1'b1, 0);
    repeat (4) put_item(OP_FAIL, '0, 1'b0, -1);
    put_item(OP_SEND, '0, 1'b0, -1);
    put_item(OP_TICK, '0, 1'b0, -1);

    // zero threshold, short hold and timeout, plus a write to an index with no register
    drain();
    write_reg(REG_FAIL_THRESH, '0);
    write_reg(REG_OPEN_TICKS, 32'd1);
    write_reg(REG_TIMEOUT, 32'd2);
    write_reg(REG_UNUSED, $urandom);
    put_item(OP_TICK, '0, 1'b0, -1);
    put_item(OP_SEND, '0, 1'b0, -1);
    put_item(OP_SEND, '0, 1'b0, -1);
    put_item(OP_RESP, '0, 1'b0, 1);
    put_item(OP_FAIL, '0, 1'b0, -1);
    repeat (3) put_item(OP_TICK, '0, 1'b0, -1);
    put_item(OP_SEND, '0, 1'b0, -1);
    repeat (2) put_item(OP_TICK, '0, 1'b0, -1);
    put_item(OP_SEND, '0, 1'b0, -1);
    put_item(OP_RESP, '0, 1'b1, 0);

    // result side stalls while sends keep coming, the table runs full
    drain();
    write_reg(REG_FAIL_THRESH, 32'd2);
    write_reg(REG_OPEN_TICKS, 32'd1);
    write_reg(REG_TIMEOUT, 32'd1000);
    hold_left = HOLD_CYCLES;
    repeat (2) put_item(OP_TICK, '0, 1'b0, -1);
    repeat (22) put_item(OP_SEND, '0, 1'b0, -1);

    run_phase(32'd3, 32'd6, 32'd5, 6, 82);
    run_phase(32'd1, 32'd0, 32'd1, 82, 6);
    run_phase({24'($urandom), 8'hFF}, 32'd4, 32'd8, 0, 0);

    // flush the table, then one send and its response with no timeout in reach
    drain();
    write_reg(REG_FAIL_THRESH, 32'd255);
    write_reg(REG_OPEN_TICKS, 32'd0);
    write_reg(REG_TIMEOUT, 32'd0);
    repeat (2) put_item(OP_TICK, '0, 1'b0, -1);
    drain();
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    put_item(OP_SEND, '0, 1'b0, -1);
    put_item(OP_RESP, '0, 1'b0, 0);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
